>>> rtl/mpq_pkg.sv
// Package for the scanning min-priority queue: depth, widths, item structs,
// status codes and sequencer states. No dependencies.
package mpq_pkg;

   // Queue geometry (legal depth 2 to 63, since entries_held is HELD_W bits)
   localparam int QUEUE_DEPTH = 32;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // Fixed item field widths
   localparam int VALUE_W = 32;
   localparam int URG_W   = 8;
   localparam int HELD_W  = 6;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT_START,
      ST_SHIFT
   } state_type;

   typedef struct packed {
      op_type             operation;
      logic [VALUE_W-1:0] value;
      logic [URG_W-1:0]   priority_req;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [VALUE_W-1:0] value_out;
      logic [HELD_W-1:0]  entries_held;
   } rsp_type;

   // One stored queue entry
   typedef struct packed {
      logic [URG_W-1:0]   urgency;
      logic [VALUE_W-1:0] payload;
   } entry_type;

endpackage

>>> rtl/min_priority_queue_scan.sv
// Bounded priority queue kept unsorted in insertion order; one entry memory
// walked by a small sequencer for the minimum scan and the compaction.
// Depends on mpq_pkg.
//
//   channel   | ports                    | handshake
//   ----------+--------------------------+-------------------------------------
//   request   | start, busy, req_item    | taken when start high and busy low
//   response  | rsp_valid, rsp_item      | one-cycle strobe, cannot be held off
//
// Enqueue and any status-only item: the result strobes in the cycle after
// the item is taken, and busy stays low, so the next item may be taken at the
// very next edge.
// Dequeue of n held entries, winner at index b: ST_SCAN reads all n entries,
// then ST_SHIFT_START and ST_SHIFT move the n - 1 - b entries above it down
// one place, one entry a cycle from the single read port of the memory.
// Reset is synchronous and empties the queue; the memory needs no clearing
// pass since only data read from held entries is ever used.
module min_priority_queue_scan (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   output logic            busy,
   input  mpq_pkg::req_type req_item,
   output logic            rsp_valid,
   output mpq_pkg::rsp_type rsp_item
);

   // Entry memory
   mpq_pkg::entry_type mem_array [mpq_pkg::QUEUE_DEPTH];
   mpq_pkg::entry_type rd_data_ff;

   // Sequencer and datapath registers
   mpq_pkg::state_type             state_ff, state_in;
   logic [mpq_pkg::CNT_W-1:0]      count_ff, count_in;
   logic [mpq_pkg::IDX_W-1:0]      rd_idx_ff, rd_idx_in;
   logic [mpq_pkg::IDX_W-1:0]      wr_idx_ff, wr_idx_in;
   logic [mpq_pkg::IDX_W-1:0]      best_idx_ff, best_idx_in;
   logic [mpq_pkg::URG_W-1:0]      best_urg_ff, best_urg_in;
   logic [mpq_pkg::VALUE_W-1:0]    best_val_ff, best_val_in;
   mpq_pkg::rsp_type               rsp_ff, rsp_in;
   logic                           rsp_valid_ff, rsp_valid_in;

   // Control decodes
   logic                           accept;
   logic                           is_full;
   logic                           is_empty;
   logic [mpq_pkg::CNT_W-1:0]      count_m1;
   logic                           scan_last;
   logic                           best_last;
   logic                           shift_last;
   logic                           take_new;
   logic                           deq_done;

   // Memory port controls
   logic [mpq_pkg::IDX_W-1:0]      rd_addr;
   logic                           mem_we;
   logic [mpq_pkg::IDX_W-1:0]      mem_waddr;
   mpq_pkg::entry_type             mem_wdata;

   assign busy      = (state_ff != mpq_pkg::ST_IDLE);
   assign accept    = start && !busy;
   assign is_full   = (count_ff == mpq_pkg::CNT_W'(mpq_pkg::QUEUE_DEPTH));
   assign is_empty  = (count_ff == '0);
   assign count_m1  = count_ff - mpq_pkg::CNT_W'(1);
   assign scan_last = (mpq_pkg::CNT_W'(rd_idx_ff) == count_m1);
   assign best_last = (mpq_pkg::CNT_W'(best_idx_ff) == count_m1);
   assign shift_last = ((mpq_pkg::CNT_W'(wr_idx_ff) + mpq_pkg::CNT_W'(1)) == count_m1);
   // Strictly lower urgency replaces the best, so the earliest wins a tie
   assign take_new  = (rd_idx_ff == '0) || (rd_data_ff.urgency < best_urg_ff);
   assign deq_done  = ((state_ff == mpq_pkg::ST_SHIFT_START) && best_last) ||
                      ((state_ff == mpq_pkg::ST_SHIFT) && shift_last);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mpq_pkg::ST_IDLE: begin
            if (accept && (req_item.operation == mpq_pkg::OP_DEQUEUE) && !is_empty) begin
               state_in = mpq_pkg::ST_SCAN;
            end
         end
         mpq_pkg::ST_SCAN: begin
            if (scan_last) begin
               state_in = mpq_pkg::ST_SHIFT_START;
            end
         end
         mpq_pkg::ST_SHIFT_START: begin
            state_in = best_last ? mpq_pkg::ST_IDLE : mpq_pkg::ST_SHIFT;
         end
         mpq_pkg::ST_SHIFT: begin
            if (shift_last) begin
               state_in = mpq_pkg::ST_IDLE;
            end
         end
         default: state_in = mpq_pkg::ST_IDLE;
      endcase
   end

   // Memory port drive per state
   always_comb begin
      rd_addr   = '0;
      mem_we    = 1'b0;
      mem_waddr = count_ff[mpq_pkg::IDX_W-1:0];
      mem_wdata = '{urgency: req_item.priority_req, payload: req_item.value};
      unique case (state_ff)
         mpq_pkg::ST_IDLE: begin
            // Append at the tail; read entry zero ahead of a scan
            mem_we = accept && (req_item.operation == mpq_pkg::OP_ENQUEUE) && !is_full;
         end
         mpq_pkg::ST_SCAN: begin
            rd_addr = mpq_pkg::IDX_W'(rd_idx_ff + 1'b1);
         end
         mpq_pkg::ST_SHIFT_START: begin
            rd_addr = mpq_pkg::IDX_W'(best_idx_ff + 1'b1);
         end
         mpq_pkg::ST_SHIFT: begin
            // Move the entry just read down one place
            rd_addr   = mpq_pkg::IDX_W'(wr_idx_ff + 2'd2);
            mem_we    = 1'b1;
            mem_waddr = wr_idx_ff;
            mem_wdata = rd_data_ff;
         end
         default: begin
            rd_addr = '0;
         end
      endcase
   end

   // Datapath next values
   always_comb begin
      count_in     = count_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      best_idx_in  = best_idx_ff;
      best_urg_in  = best_urg_ff;
      best_val_in  = best_val_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;

      unique case (state_ff)
         mpq_pkg::ST_IDLE: begin
            rd_idx_in = '0;
            if (accept) begin
               if (req_item.operation == mpq_pkg::OP_ENQUEUE) begin
                  rsp_valid_in     = 1'b1;
                  rsp_in.value_out = '0;
                  if (is_full) begin
                     rsp_in.status       = mpq_pkg::STATUS_FULL;
                     rsp_in.entries_held = mpq_pkg::HELD_W'(count_ff);
                  end else begin
                     count_in            = count_ff + mpq_pkg::CNT_W'(1);
                     rsp_in.status       = mpq_pkg::STATUS_OK;
                     rsp_in.entries_held = mpq_pkg::HELD_W'(count_ff + mpq_pkg::CNT_W'(1));
                  end
               end else if (is_empty) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.status       = mpq_pkg::STATUS_EMPTY;
                  rsp_in.value_out    = '0;
                  rsp_in.entries_held = '0;
               end
            end
         end
         mpq_pkg::ST_SCAN: begin
            // Track the most urgent entry seen so far
            if (take_new) begin
               best_idx_in = rd_idx_ff;
               best_urg_in = rd_data_ff.urgency;
               best_val_in = rd_data_ff.payload;
            end
            rd_idx_in = mpq_pkg::IDX_W'(rd_idx_ff + 1'b1);
         end
         mpq_pkg::ST_SHIFT_START: begin
            wr_idx_in = best_idx_ff;
         end
         mpq_pkg::ST_SHIFT: begin
            wr_idx_in = mpq_pkg::IDX_W'(wr_idx_ff + 1'b1);
         end
         default: begin
            rd_idx_in = '0;
         end
      endcase

      // Close out a dequeue
      if (deq_done) begin
         count_in            = count_m1;
         rsp_valid_in        = 1'b1;
         rsp_in.status       = mpq_pkg::STATUS_OK;
         rsp_in.value_out    = best_val_ff;
         rsp_in.entries_held = mpq_pkg::HELD_W'(count_m1);
      end
   end

   // Entry memory: one write, one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_array[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= mem_array[rd_addr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mpq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rd_idx_ff   <= rd_idx_in;
      wr_idx_ff   <= wr_idx_in;
      best_idx_ff <= best_idx_in;
      best_urg_ff <= best_urg_in;
      best_val_ff <= best_val_in;
      rsp_ff      <= rsp_in;
   end

endmodule

>>> tb/sv/min_priority_queue_scan_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for min_priority_queue_scan: directed and random
// enqueue/dequeue items checked against an in-bench queue predictor.
// Depends on mpq_pkg and the min_priority_queue_scan RTL.
module min_priority_queue_scan_tb;

   localparam int RANDOM_ITEMS = 1500;
   localparam int IDLE_LIMIT   = 2000;  // cycles with no item moving
   localparam int DRAIN_CYCLES = 2 * mpq_pkg::QUEUE_DEPTH + 16;
   localparam int PHASE_ITEMS  = 200;

   logic             clock    = 1'b0;
   logic             reset    = 1'b1;
   logic             start    = 1'b0;
   mpq_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_valid;
   mpq_pkg::rsp_type rsp_item;

   min_priority_queue_scan u_dut (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .rsp_valid(rsp_valid),
      .rsp_item (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   wire item_taken = start && !busy;

   // Stimulus waiting to be driven and results waiting to arrive
   mpq_pkg::req_type pending_items[$];
   mpq_pkg::rsp_type expected_rsps[$];
   int unsigned items_taken   = 0;
   int unsigned rsps_checked  = 0;
   int unsigned mismatches    = 0;
   int unsigned idle_cycles   = 0;

   // Predictor state: unsorted array in insertion order
   logic [mpq_pkg::VALUE_W-1:0] model_payloads [mpq_pkg::QUEUE_DEPTH];
   logic [mpq_pkg::URG_W-1:0]   model_urgencies[mpq_pkg::QUEUE_DEPTH];
   int unsigned        model_held     = 0;
   int unsigned        peak_held      = 0;
   int unsigned        enq_count      = 0;
   int unsigned        deq_count      = 0;
   int unsigned        full_drops     = 0;
   int unsigned        empty_deqs     = 0;

   // Apply one item to the predicted queue and return its result
   function automatic mpq_pkg::rsp_type predict_queue_step(mpq_pkg::req_type r);
      mpq_pkg::rsp_type o;
      int unsigned      best;
      int unsigned      i;
      o.status    = mpq_pkg::STATUS_OK;
      o.value_out = '0;
      if (r.operation == mpq_pkg::OP_ENQUEUE) begin
         enq_count++;
         if (model_held >= mpq_pkg::QUEUE_DEPTH) begin
            o.status = mpq_pkg::STATUS_FULL;
            full_drops++;
         end else begin
            model_payloads[model_held]  = r.value;
            model_urgencies[model_held] = r.priority_req;
            model_held++;
            if (model_held > peak_held) peak_held = model_held;
         end
      end else begin
         deq_count++;
         if (model_held == 0) begin
            o.status = mpq_pkg::STATUS_EMPTY;
            empty_deqs++;
         end else begin
            // lowest urgency wins, earliest entry on a tie
            best = 0;
            for (i = 1; i < model_held; i++) begin
               if (model_urgencies[i] < model_urgencies[best]) best = i;
            end
            o.value_out = model_payloads[best];
            // close the gap, keeping insertion order
            for (i = best; i + 1 < model_held; i++) begin
               model_payloads[i]  = model_payloads[i + 1];
               model_urgencies[i] = model_urgencies[i + 1];
            end
            model_held--;
         end
      end
      o.entries_held = mpq_pkg::HELD_W'(model_held);
      return o;
   endfunction

   task automatic add_enqueue(logic [mpq_pkg::VALUE_W-1:0] val,
                              logic [mpq_pkg::URG_W-1:0] urg);
      mpq_pkg::req_type r;
      r.operation    = mpq_pkg::OP_ENQUEUE;
      r.value        = val;
      r.priority_req = urg;
      pending_items.push_back(r);
   endtask

   // value and priority are don't-care on dequeue: fill them with noise
   task automatic add_dequeue();
      mpq_pkg::req_type r;
      r.operation    = mpq_pkg::OP_DEQUEUE;
      r.value        = $urandom;
      r.priority_req = mpq_pkg::URG_W'($urandom);
      pending_items.push_back(r);
   endtask

   function automatic logic [mpq_pkg::URG_W-1:0] pick_urgency();
      int unsigned sel;
      sel = $urandom_range(0, 5);
      if (sel < 2) return mpq_pkg::URG_W'($urandom_range(0, 3));  // crowd ties
      if (sel == 2) return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      return mpq_pkg::URG_W'($urandom);
   endfunction

   // Sender idle chance per phase; the receiver cannot stall results
   function automatic int unsigned idle_percent();
      case ((items_taken / PHASE_ITEMS) % 4)
         1:       return 67;
         3:       return 37;
         default: return 0;
      endcase
   endfunction

   // Driver: take the item on a handshake, then present the next one
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && !item_taken) begin
         // hold the item until busy drops
      end else begin
         if (item_taken) begin
            expected_rsps.push_back(predict_queue_step(req_item));
            void'(pending_items.pop_front());
            items_taken++;
         end
         if (pending_items.size() != 0 && $urandom_range(1, 100) > idle_percent()) begin
            start    <= 1'b1;
            req_item <= pending_items[0];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: compare each strobed result with the oldest expectation
   always @(posedge clock) begin
      mpq_pkg::rsp_type want;
      if (!reset && rsp_valid) begin
         if (expected_rsps.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%t: result with nothing expected: status %0d value %h held %0d",
                        $realtime, rsp_item.status, rsp_item.value_out,
                        rsp_item.entries_held);
         end else begin
            want = expected_rsps.pop_front();
            rsps_checked++;
            if (rsp_item.status !== want.status || rsp_item.value_out !== want.value_out
                || rsp_item.entries_held !== want.entries_held) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%t: result %0d: want %0d/%h/%0d, got %0d/%h/%0d",
                           $realtime, rsps_checked, want.status, want.value_out,
                           want.entries_held, rsp_item.status, rsp_item.value_out,
                           rsp_item.entries_held);
            end
         end
      end
   end

   // Watchdog: count cycles in which no item moves either way
   always @(posedge clock) begin
      if (reset || item_taken || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      int unsigned mode;
      int unsigned run_len;
      int unsigned enq_pct;
      int unsigned n;
      int unsigned random_items;
      bit          timed_out;

      // Directed: empty dequeue, field extremes, ties in insertion order
      add_dequeue();
      add_enqueue(32'h0000_0000, 8'hFF);
      add_enqueue(32'hFFFF_FFFF, 8'h00);
      add_enqueue(32'h5555_AAAA, 8'h80);
      add_enqueue(32'hA5A5_5A5A, 8'h00);
      add_enqueue(32'h0000_0001, 8'hFF);
      add_enqueue(32'hAAAA_5555, 8'h7F);
      repeat (6) add_dequeue();
      add_dequeue();
      add_enqueue(32'h1111_1111, 8'h07);
      add_enqueue(32'h2222_2222, 8'h07);
      add_enqueue(32'h3333_3333, 8'h07);
      add_enqueue(32'h0F0F_0F0F, 8'h06);
      repeat (5) add_dequeue();

      // Random: fill, drain and mixed runs so the queue hits full and empty
      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         mode    = $urandom_range(0, 3);
         run_len = $urandom_range(8, 64);
         case (mode)
            0:       enq_pct = 90;
            1:       enq_pct = 10;
            default: enq_pct = 50;
         endcase
         for (n = 0; n < run_len; n++) begin
            if ($urandom_range(1, 100) <= enq_pct) add_enqueue($urandom, pick_urgency());
            else add_dequeue();
         end
         random_items += run_len;
      end

      // Reset once, then run until every result is in
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      timed_out = 1'b0;
      while (!(pending_items.size() == 0 && !start && expected_rsps.size() == 0)) begin
         @(posedge clock);
         if (idle_cycles >= IDLE_LIMIT) begin
            timed_out = 1'b1;
            break;
         end
      end
      if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d items: %0d enqueues (%0d dropped when full), %0d dequeues",
               items_taken, enq_count, full_drops, deq_count);
      $display("(%0d on empty); peak occupancy %0d of %0d; %0d results checked",
               empty_deqs, peak_held, mpq_pkg::QUEUE_DEPTH, rsps_checked);
      if (timed_out) $display("Watchdog expired after %0d idle cycles", idle_cycles);
      if (expected_rsps.size() != 0)
         $display("%0d expected results never arrived", expected_rsps.size());
      if (!timed_out && mismatches == 0 && expected_rsps.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
